// ===== design/vgs_pkg.sv =====
// ----------------------------------------------------------------------------
// vgs_pkg
// Shared types, codes and reset values for the vacuum gripper sequencer.
// ----------------------------------------------------------------------------
package vgs_pkg;

    // Width of the time-since-last-command counter
    localparam int TIME_BITS = 16;
    // Width of the configuration registers and phase counter
    localparam int REG_BITS  = 16;
    // Width used when comparing the time counter against the command gap
    localparam int CMP_BITS  = (TIME_BITS > REG_BITS) ? TIME_BITS : REG_BITS;

    localparam int CODE_BITS = 8;
    localparam int CFG_IDX_BITS = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_GAP    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRAB_TIME  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OPEN_TIME  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY_TIME = 2'd3;

    // Register reset values
    localparam logic [REG_BITS-1:0] RST_MIN_GAP    = 16'd500;
    localparam logic [REG_BITS-1:0] RST_GRAB_TIME  = 16'd300;
    localparam logic [REG_BITS-1:0] RST_OPEN_TIME  = 16'd500;
    localparam logic [REG_BITS-1:0] RST_DELAY_TIME = 16'd50;

    // Gripper command codes
    localparam logic signed [CODE_BITS-1:0] CODE_STOP    = 8'sd0;
    localparam logic signed [CODE_BITS-1:0] CODE_GRAB    = 8'sd1;
    localparam logic signed [CODE_BITS-1:0] CODE_RELEASE = 8'sd2;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_HOLDING   = 2'd1,
        MODE_RELEASING = 2'd2,
        MODE_STOPPED   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_NONE   = 2'd0,
        PH_SETTLE = 2'd1,
        PH_DELAY  = 2'd2,
        PH_OPEN   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        OUT_ACTED     = 3'd0,
        OUT_DROPPED   = 3'd1,
        OUT_DUPLICATE = 3'd2,
        OUT_UNKNOWN   = 3'd3,
        OUT_TICK      = 3'd4
    } outcome_t;

    // Configuration register set
    typedef struct packed {
        logic [REG_BITS-1:0] min_command_gap;
        logic [REG_BITS-1:0] grab_settle_time;
        logic [REG_BITS-1:0] vent_open_time;
        logic [REG_BITS-1:0] vent_delay_time;
    } cfg_t;

    // One input item
    typedef struct packed {
        logic                        cmd;
        logic signed [CODE_BITS-1:0] command_code;
    } item_t;

    // One result item, packed first field highest
    typedef struct packed {
        outcome_t outcome;
        logic     grip_done;
        mode_t    gripper_mode;
        logic     valve_on;
        logic     pump_on;
    } result_t;

endpackage

// ===== design/vgs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// vgs_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module vgs_cfg_regs
    import vgs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_addr,
    input  logic [REG_BITS-1:0]     cfg_wdata,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MIN_GAP:    cfg_next.min_command_gap  = cfg_wdata;
                CFG_GRAB_TIME:  cfg_next.grab_settle_time = cfg_wdata;
                CFG_OPEN_TIME:  cfg_next.vent_open_time   = cfg_wdata;
                CFG_DELAY_TIME: cfg_next.vent_delay_time  = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_command_gap  <= RST_MIN_GAP;
            cfg_reg.grab_settle_time <= RST_GRAB_TIME;
            cfg_reg.vent_open_time   <= RST_OPEN_TIME;
            cfg_reg.vent_delay_time  <= RST_DELAY_TIME;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/vgs_in_reg.sv =====
// ----------------------------------------------------------------------------
// vgs_in_reg
// Input register: captures one transfer per cycle from the slave side while the held item is empty or leaves.
// ----------------------------------------------------------------------------
module vgs_in_reg
    import vgs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    output item_t item,
    input  logic  item_take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept whenever the held item is empty or leaves this cycle
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload: load on a transfer only
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/vgs_core.sv =====
// ----------------------------------------------------------------------------
// vgs_core
// Gripper state, one-pass update per item and the result register.
// ----------------------------------------------------------------------------
module vgs_core
    import vgs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    item_valid,
    input  item_t   item,
    output logic    item_take,
    output logic    res_valid,
    output result_t res,
    input  logic    res_ready
);

    mode_t                mode_reg,   mode_next;
    phase_t               phase_reg,  phase_next;
    logic [REG_BITS-1:0]  count_reg,  count_next;
    logic [TIME_BITS-1:0] since_reg,  since_next;
    logic                 pump_reg,   pump_next;
    logic                 valve_reg,  valve_next;
    logic                 done_reg,   done_next;
    outcome_t             outcome_next;

    logic                 res_valid_reg, res_valid_next;
    result_t              res_reg;

    logic [REG_BITS-1:0]  count_inc;
    logic [REG_BITS-1:0]  duration;
    logic                 gap_short;

    // Move an item into the result register when that register is free or its result leaves
    assign item_take      = item_valid && (!res_valid_reg || res_ready);
    assign res_valid_next = item_take || (res_valid_reg && !res_ready);

    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign gap_short = CMP_BITS'(since_reg) < CMP_BITS'(cfg.min_command_gap);

    // Pick the duration of the running phase
    always_comb
    begin
        case (phase_reg)
            PH_SETTLE: duration = cfg.grab_settle_time;
            PH_DELAY:  duration = cfg.vent_delay_time;
            PH_OPEN:   duration = cfg.vent_open_time;
            default:   duration = '0;
        endcase
    end

    // Next state for a tick or a command
    always_comb
    begin
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        since_next   = since_reg;
        pump_next    = pump_reg;
        valve_next   = valve_reg;
        done_next    = done_reg;
        outcome_next = OUT_TICK;

        if (!item.cmd)
        begin
            // Tick: advance the saturating counters, then check for expiry
            if (since_reg != '1)
            begin
                since_next = since_reg + 1'b1;
            end
            if (phase_reg != PH_NONE)
            begin
                count_next = count_inc;
                if (count_inc >= duration)
                begin
                    count_next = '0;
                    case (phase_reg)
                        PH_SETTLE:
                        begin
                            done_next  = 1'b1;
                            phase_next = PH_NONE;
                        end
                        PH_DELAY:
                        begin
                            valve_next = 1'b1;
                            phase_next = PH_OPEN;
                        end
                        default:
                        begin
                            valve_next = 1'b0;
                            mode_next  = MODE_IDLE;
                            done_next  = 1'b1;
                            phase_next = PH_NONE;
                        end
                    endcase
                end
            end
        end
        else if (gap_short)
        begin
            // Drop a command that comes too soon
            outcome_next = OUT_DROPPED;
        end
        else
        begin
            since_next   = '0;
            outcome_next = OUT_UNKNOWN;
            if (item.command_code == CODE_GRAB)
            begin
                if (mode_reg == MODE_HOLDING || mode_reg == MODE_RELEASING)
                begin
                    outcome_next = OUT_DUPLICATE;
                end
                else
                begin
                    outcome_next = OUT_ACTED;
                    done_next    = 1'b0;
                    valve_next   = 1'b0;
                    pump_next    = 1'b1;
                    mode_next    = MODE_HOLDING;
                    phase_next   = PH_SETTLE;
                    count_next   = '0;
                end
            end
            else if (item.command_code == CODE_RELEASE)
            begin
                if (mode_reg == MODE_RELEASING)
                begin
                    outcome_next = OUT_DUPLICATE;
                end
                else
                begin
                    outcome_next = OUT_ACTED;
                    done_next    = 1'b0;
                    mode_next    = MODE_RELEASING;
                    pump_next    = 1'b0;
                    phase_next   = PH_DELAY;
                    count_next   = '0;
                end
            end
            else if (item.command_code == CODE_STOP)
            begin
                if (mode_reg == MODE_STOPPED)
                begin
                    outcome_next = OUT_DUPLICATE;
                end
                else
                begin
                    outcome_next = OUT_ACTED;
                    pump_next    = 1'b0;
                    valve_next   = 1'b0;
                    mode_next    = MODE_STOPPED;
                    done_next    = 1'b1;
                    phase_next   = PH_NONE;
                    count_next   = '0;
                end
            end
        end
    end

    // Hold the gripper state; update only when an item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            phase_reg     <= PH_NONE;
            count_reg     <= '0;
            since_reg     <= '0;
            pump_reg      <= 1'b0;
            valve_reg     <= 1'b0;
            done_reg      <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (item_take)
            begin
                mode_reg  <= mode_next;
                phase_reg <= phase_next;
                count_reg <= count_next;
                since_reg <= since_next;
                pump_reg  <= pump_next;
                valve_reg <= valve_next;
                done_reg  <= done_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            res_reg.pump_on      <= pump_next;
            res_reg.valve_on     <= valve_next;
            res_reg.gripper_mode <= mode_next;
            res_reg.grip_done    <= done_next;
            res_reg.outcome      <= outcome_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== design/vacuum_gripper_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// vacuum_gripper_sequencer_unit
// Vacuum gripper sequencer: millisecond ticks and commands in, line levels,
// mode and outcome out, one result for every item.
// ----------------------------------------------------------------------------
// Each transfer on the slave side is a tick (s_tuser low) or a gripper
// command (s_tuser high, code in s_tdata) and yields exactly one result on the
// master side. The block takes one item every clock cycle while not stalled by
// backpressure; a result passes through the input register and then the
// result register, where the whole state update is done in a single pass.
// Backpressure on m_tready stalls the input register only once
// both registers hold an item. Write the registers only while no item is in
// flight.
module vacuum_gripper_sequencer_unit
    import vgs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Configuration write port
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_addr,
    input  logic [REG_BITS-1:0]     cfg_wdata,
    // Slave side
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [7:0] command_code
    input  logic                    s_tuser,   // [0] cmd
    // Master side
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata    // [0] pump_on, [1] valve_on,
                                               // [3:2] gripper_mode,
                                               // [4] grip_done, [7:5] outcome
);

    cfg_t    cfg;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    item_take;
    result_t res;

    assign in_item.cmd          = s_tuser;
    assign in_item.command_code = s_tdata;

    vgs_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vgs_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    vgs_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

    assign m_tdata = res;

`ifndef NO_ASSERTIONS
    // Pump and valve are never driven together
    a_lines_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("pump and valve both on");

    // While releasing the pump is off
    a_release_pump_off: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[3:2] == MODE_RELEASING) |-> !m_tdata[0])
        else $error("pump on while releasing");

    // An item leaving the input register shows up as a result next cycle
    a_take_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> m_tvalid)
        else $error("result lost after transfer into result register");

    // A tick result carries the tick outcome when the input was a tick
    a_tick_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && !item.cmd) |=> (m_tdata[7:5] == OUT_TICK))
        else $error("tick item without tick outcome");
`endif

endmodule

// ===== tb/vacuum_gripper_sequencer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// vacuum_gripper_sequencer_unit_tb
// Self-checking bench for the gripper sequencer. A queue of ticks and
// commands feeds a clocked stream driver. An in-bench model of the
// sequencer predicts pump, valve, mode, done and outcome for every accepted
// transfer. A clocked monitor checks each result, field by field, in order.
// Register settings change between phases, once the block has drained.
// ----------------------------------------------------------------------------
module vacuum_gripper_sequencer_unit_tb;
    import vgs_pkg::*;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_addr  = '0;
    logic [REG_BITS-1:0]     cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata   = '0;   // [7:0] command_code
    logic                    s_tuser   = 1'b0; // [0] cmd
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [7:0]              m_tdata;          // [0] pump_on, [1] valve_on,
                                               // [3:2] gripper_mode,
                                               // [4] grip_done, [7:5] outcome

    // Model copy of the registers and the sequencer state
    cfg_t                    regs_model;
    mode_t                   mode_model;
    phase_t                  phase_model;
    logic [REG_BITS-1:0]     phase_ms;
    logic [TIME_BITS-1:0]    since_cmd_ms;
    logic                    pump_model;
    logic                    valve_model;
    logic                    done_model;

    item_t                   pending_items[$];
    result_t                 expected_results[$];
    bit                      steady;
    int                      errors;
    int                      settings_applied;
    int                      outcome_seen[5];

    vacuum_gripper_sequencer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock, period 4
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Advance the gripper model by one item and return the line levels, mode, done and outcome after it
    function automatic result_t gripper_step(input item_t it);
        result_t             res;
        logic [REG_BITS-1:0] span;
        res.outcome = OUT_TICK;
        if (!it.cmd)
        begin
            if (since_cmd_ms != '1)
                since_cmd_ms++;
            if (phase_model != PH_NONE)
            begin
                if (phase_ms != '1)
                    phase_ms++;
                case (phase_model)
                    PH_SETTLE: span = regs_model.grab_settle_time;
                    PH_DELAY:  span = regs_model.vent_delay_time;
                    default:   span = regs_model.vent_open_time;
                endcase
                // Phase expires once its count reaches the duration
                if (phase_ms >= span)
                begin
                    case (phase_model)
                        PH_SETTLE:
                        begin
                            done_model  = 1'b1;
                            phase_model = PH_NONE;
                        end
                        PH_DELAY:
                        begin
                            valve_model = 1'b1;
                            phase_model = PH_OPEN;
                        end
                        default:
                        begin
                            valve_model = 1'b0;
                            mode_model  = MODE_IDLE;
                            done_model  = 1'b1;
                            phase_model = PH_NONE;
                        end
                    endcase
                    phase_ms = '0;
                end
            end
        end
        else if (since_cmd_ms < regs_model.min_command_gap)
            res.outcome = OUT_DROPPED;
        else
        begin
            // A command past the rate check restarts the gap, whatever it is
            since_cmd_ms = '0;
            if (it.command_code == CODE_GRAB)
            begin
                if (mode_model == MODE_HOLDING || mode_model == MODE_RELEASING)
                    res.outcome = OUT_DUPLICATE;
                else
                begin
                    res.outcome = OUT_ACTED;
                    done_model  = 1'b0;
                    valve_model = 1'b0;
                    pump_model  = 1'b1;
                    mode_model  = MODE_HOLDING;
                    phase_model = PH_SETTLE;
                    phase_ms    = '0;
                end
            end
            else if (it.command_code == CODE_RELEASE)
            begin
                if (mode_model == MODE_RELEASING)
                    res.outcome = OUT_DUPLICATE;
                else
                begin
                    res.outcome = OUT_ACTED;
                    done_model  = 1'b0;
                    pump_model  = 1'b0;
                    mode_model  = MODE_RELEASING;
                    phase_model = PH_DELAY;
                    phase_ms    = '0;
                end
            end
            else if (it.command_code == CODE_STOP)
            begin
                if (mode_model == MODE_STOPPED)
                    res.outcome = OUT_DUPLICATE;
                else
                begin
                    res.outcome = OUT_ACTED;
                    pump_model  = 1'b0;
                    valve_model = 1'b0;
                    mode_model  = MODE_STOPPED;
                    done_model  = 1'b1;
                    phase_model = PH_NONE;
                    phase_ms    = '0;
                end
            end
            else
                res.outcome = OUT_UNKNOWN;
        end
        res.pump_on      = pump_model;
        res.valve_on     = valve_model;
        res.gripper_mode = mode_model;
        res.grip_done    = done_model;
        return res;
    endfunction

    function automatic void check_field(input string label, input logic [2:0] want,
                                        input logic [2:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
        end
    endfunction

    // Driver: present the next queued item, predict on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        item_t next_item;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(gripper_step(item_t'({s_tuser, s_tdata})));
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 25))
                begin
                    next_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_item.cmd;
                    s_tdata  <= next_item.command_code;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata);
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("pump_on", 3'(want.pump_on), 3'(got.pump_on));
                    check_field("valve_on", 3'(want.valve_on), 3'(got.valve_on));
                    check_field("gripper_mode", 3'(want.gripper_mode),
                                3'(got.gripper_mode));
                    check_field("grip_done", 3'(want.grip_done), 3'(got.grip_done));
                    check_field("outcome", want.outcome, got.outcome);
                    outcome_seen[want.outcome]++;
                end
            end
            m_tready <= steady || $urandom_range(99) >= 25;
        end
    end

    task automatic add_tick(input int count);
        repeat (count)
            pending_items.push_back(item_t'{cmd: 1'b0, command_code: 8'sd0});
    endtask

    task automatic add_cmd(input logic signed [CODE_BITS-1:0] code);
        pending_items.push_back(item_t'{cmd: 1'b1, command_code: code});
    endtask

    // Hold until every queued item has been taken and every result checked
    task automatic drain_block();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [REG_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Drain, then write all four registers and mirror them in the model
    task automatic apply_setting(input logic [REG_BITS-1:0] gap, input logic [REG_BITS-1:0] grab,
                                 input logic [REG_BITS-1:0] open,
                                 input logic [REG_BITS-1:0] delay);
        drain_block();
        write_reg(CFG_MIN_GAP, gap);
        write_reg(CFG_GRAB_TIME, grab);
        write_reg(CFG_OPEN_TIME, open);
        write_reg(CFG_DELAY_TIME, delay);
        regs_model.min_command_gap  = gap;
        regs_model.grab_settle_time = grab;
        regs_model.vent_open_time   = open;
        regs_model.vent_delay_time  = delay;
        settings_applied++;
    endtask

    // Stimulus and verdict
    initial
    begin
        int        roll;
        logic [7:0] raw_code;
        regs_model   = '{RST_MIN_GAP, RST_GRAB_TIME, RST_OPEN_TIME, RST_DELAY_TIME};
        mode_model   = MODE_IDLE;
        phase_model  = PH_NONE;
        phase_ms     = '0;
        since_cmd_ms = '0;
        pump_model   = 1'b0;
        valve_model  = 1'b0;
        done_model   = 1'b1;
        steady       = 1'b0;
        errors       = 0;
        settings_applied = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Start-up: commands drop until the reset gap has passed
        add_cmd(CODE_GRAB);
        add_cmd(CODE_RELEASE);
        add_cmd(CODE_STOP);
        add_tick(2);

        // Directed: no gap, short timings, zero vent delay
        apply_setting(16'd0, 16'd2, 16'd3, 16'd0);
        add_cmd(CODE_STOP);
        add_cmd(CODE_STOP);                 // repeated stop
        add_cmd(-8'sd128);                  // unknown codes at both ends
        add_cmd(8'sd127);
        add_cmd(8'sd3);
        add_cmd(CODE_GRAB);
        add_cmd(CODE_GRAB);                 // repeated grab
        add_tick(2);                        // settle expires
        add_cmd(CODE_RELEASE);
        add_cmd(CODE_RELEASE);              // repeated release
        add_tick(1);                        // zero delay opens the valve
        add_cmd(CODE_GRAB);                 // grab while venting
        add_tick(3);                        // valve closes, back to idle
        add_cmd(CODE_RELEASE);
        add_cmd(CODE_STOP);                 // cancel a release
        add_cmd(CODE_GRAB);
        add_cmd(CODE_RELEASE);              // cancel a grab settle

        // Rate check at the edge of the gap
        apply_setting(16'd3, 16'd2, 16'd3, 16'd1);
        add_tick(2);
        add_cmd(CODE_GRAB);
        add_tick(1);
        add_cmd(CODE_GRAB);

        // Random phases over several settings, one without idling
        for (int phase_idx = 0; phase_idx < 6; phase_idx++)
        begin
            if (phase_idx == 0)
                apply_setting(16'd0, 16'd0, 16'd0, 16'd0);
            else if (phase_idx == 1)
                apply_setting(16'd1, 16'd3, 16'd2, 16'd1);
            else
                apply_setting(REG_BITS'($urandom_range(3)), REG_BITS'($urandom_range(6)),
                              REG_BITS'($urandom_range(6)), REG_BITS'($urandom_range(6)));
            steady = (phase_idx == 3);
            for (int n = 0; n < 130; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 55)
                    add_tick(1);
                else if (roll < 90)
                    add_cmd(CODE_BITS'($urandom_range(2)));
                else
                begin
                    raw_code = 8'($urandom_range(255));
                    add_cmd(raw_code);
                end
            end
        end
        drain_block();
        steady = 1'b0;

        // Full-scale timings: widest gap drops a stop command, longest settle
        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_tick(4);
        add_cmd(CODE_STOP);
        apply_setting(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_cmd(CODE_GRAB);
        add_tick(8);

        drain_block();
        repeat (10) @(posedge clk);
        $display("Checked %0d ticks, %0d actions, %0d rate drops, %0d repeats, %0d unknown codes",
                 outcome_seen[OUT_TICK], outcome_seen[OUT_ACTED], outcome_seen[OUT_DROPPED],
                 outcome_seen[OUT_DUPLICATE], outcome_seen[OUT_UNKNOWN]);
        $display("Over %0d register settings, from all-zero to all-ones timings",
                 settings_applied);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Timeout
    initial
    begin
        #200000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
